### hw/rtl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds field widths, register indexes, fixed constants and the stage payload types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package bpc_pkg;

    // Field and coefficient widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int PRESS_W = 32;
    localparam int TEMP_W  = 19;

    // Intermediate widths
    localparam int DT_W    = 25;
    localparam int OFF_W   = 36;
    localparam int SENS_W  = 35;
    localparam int T2_W    = 17;
    localparam int CORR_W  = 38;

    // Register file
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TCS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TCO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TREF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPSENS = 3'd5;

    // Temperature thresholds in hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

    // Register stages from input to output
    localparam int PIPE_DEPTH = 9;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tempsens;
    } coef_t;

    // First-order results
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } first_t;

    // Second-order corrected temperature and correction terms
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [CORR_W-1:0]        off2;
        logic [CORR_W-1:0]        sens2;
    } corr_t;

endpackage

`default_nettype wire

### hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the pressure compensation block.
// Input channel carries the raw readings, output channel the compensated values.
// Depends on bpc_pkg for field widths.
`default_nettype none

interface bpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::RAW_W-1:0]  raw_press;
    logic [bpc_pkg::RAW_W-1:0]  raw_temp;

    modport source (output valid, output raw_press, output raw_temp, input ready);
    modport sink   (input valid, input raw_press, input raw_temp, output ready);
endinterface

interface bpc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpc_pkg::PRESS_W-1:0] pressure_out;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp_out;

    modport source (output valid, output pressure_out, output temp_out, input ready);
    modport sink   (input valid, input pressure_out, input temp_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
// Holds the coefficient registers and chains the front, correction and pressure stages.
// Depends on bpc_pkg, bpc_if, bpc_front, bpc_corr and bpc_press.
//
// Usage:
//   in_ch carries one item of raw readings (raw_press, raw_temp); out_ch returns one
//   item with pressure_out (0.01 mbar, wrapped to 32 bits) and temp_out (0.01 C).
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   Six 16-bit coefficients are written through cfg_we/cfg_index/cfg_data; the user
//   must do so only while no item is in flight; the block does not enforce this.
//   Unknown indexes are ignored. Each item passes through every register stage;
//   one item per cycle is sustained while out_ch.ready is high. The nine register
//   stages are set by the chain of dependent multiplies (coefficient products,
//   squares, D1 times sensitivity).
//   Each stage has its own valid bit and advances when the next one is free, so
//   a stalled receiver holds the output item steady while upstream bubbles fill;
//   in_ch.ready drops only when all nine stages hold items.
//   Reset clears all valid bits and sets every coefficient to zero.
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bpc_in_if.sink                             in_ch,
    bpc_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpc_pkg::COEF_W-1:0]    cfg_data
);

    bpc_pkg::coef_t  coef_reg;
    logic            front_valid, front_ready;
    bpc_pkg::first_t front_data;
    logic            corr_valid, corr_ready;
    bpc_pkg::corr_t  corr_data;

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::CFG_SENS:     coef_reg.sens     <= cfg_data;
                bpc_pkg::CFG_OFF:      coef_reg.off      <= cfg_data;
                bpc_pkg::CFG_TCS:      coef_reg.tcs      <= cfg_data;
                bpc_pkg::CFG_TCO:      coef_reg.tco      <= cfg_data;
                bpc_pkg::CFG_TREF:     coef_reg.tref     <= cfg_data;
                bpc_pkg::CFG_TEMPSENS: coef_reg.tempsens <= cfg_data;
                default:               coef_reg          <= coef_reg;
            endcase
        end
    end

    bpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .raw_press (in_ch.raw_press),
        .raw_temp  (in_ch.raw_temp),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    bpc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    bpc_press u_press (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (corr_valid),
        .in_ready     (corr_ready),
        .in_data      (corr_data),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .pressure_out (out_ch.pressure_out),
        .temp_out     (out_ch.temp_out)
    );

endmodule

`default_nettype wire

### hw/rtl/bpc_front.sv
// First-order stages: temperature difference, coefficient products, TEMP/OFF/SENS.
// Three register stages with per-stage valid and a ready chain.
// Depends on bpc_pkg.
`default_nettype none

module bpc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bpc_pkg::coef_t            coef,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [bpc_pkg::RAW_W-1:0] raw_press,
    input  wire logic [bpc_pkg::RAW_W-1:0] raw_temp,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output bpc_pkg::first_t                out_data
);

    localparam int PROD_W = 42;
    localparam int SQ_W   = 50;

    logic en1, en2, en3;

    // Stage 1: dT
    logic                                s1_v_reg;
    logic [bpc_pkg::RAW_W-1:0]           s1_d1_reg;
    logic signed [bpc_pkg::DT_W-1:0]     s1_dt_reg;
    logic signed [bpc_pkg::DT_W-1:0]     s1_dt_next;

    // Stage 2: products
    logic                                s2_v_reg;
    logic [bpc_pkg::RAW_W-1:0]           s2_d1_reg;
    logic signed [PROD_W-1:0]            s2_ptemp_reg, s2_ptemp_next;
    logic signed [PROD_W-1:0]            s2_poff_reg, s2_poff_next;
    logic signed [PROD_W-1:0]            s2_psens_reg, s2_psens_next;
    logic [47:0]                         s2_psq_reg, s2_psq_next;
    logic signed [SQ_W-1:0]              sq_full;

    // Stage 3: first-order values
    logic                                s3_v_reg;
    bpc_pkg::first_t                     s3_data_reg, s3_data_next;
    logic signed [PROD_W-1:0]            q_temp, q_off, q_sens;

    // Advance a stage when it is empty or the next one advances
    assign en3      = !s3_v_reg || out_ready;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign in_ready = en1;

    assign s1_dt_next = $signed({1'b0, raw_temp}) - $signed({1'b0, coef.tref, 8'b0});

    // Coefficient products and dT squared
    always_comb
    begin
        s2_ptemp_next = PROD_W'(s1_dt_reg) * PROD_W'($signed({1'b0, coef.tempsens}));
        s2_poff_next  = PROD_W'(s1_dt_reg) * PROD_W'($signed({1'b0, coef.tco}));
        s2_psens_next = PROD_W'(s1_dt_reg) * PROD_W'($signed({1'b0, coef.tcs}));
        sq_full       = SQ_W'(s1_dt_reg) * SQ_W'(s1_dt_reg);
        s2_psq_next   = sq_full[47:0];
    end

    // Scale with truncation toward zero and add the base terms
    always_comb
    begin
        q_temp = (s2_ptemp_reg + (s2_ptemp_reg[PROD_W-1] ? 42'sd8388607 : 42'sd0)) >>> 23;
        q_off  = (s2_poff_reg + (s2_poff_reg[PROD_W-1] ? 42'sd127 : 42'sd0)) >>> 7;
        q_sens = (s2_psens_reg + (s2_psens_reg[PROD_W-1] ? 42'sd255 : 42'sd0)) >>> 8;
        s3_data_next.d1   = s2_d1_reg;
        s3_data_next.temp = $signed(q_temp[bpc_pkg::TEMP_W-1:0]) + bpc_pkg::TEMP_REF;
        s3_data_next.off  = $signed({4'b0, coef.off, 16'b0})
                          + $signed(q_off[bpc_pkg::OFF_W-1:0]);
        s3_data_next.sens = $signed({4'b0, coef.sens, 15'b0})
                          + $signed(q_sens[bpc_pkg::SENS_W-1:0]);
        s3_data_next.t2   = s2_psq_reg[47:31];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= in_valid;
            if (en2)
                s2_v_reg <= s1_v_reg;
            if (en3)
                s3_v_reg <= s2_v_reg;
        end
    end

    // Payload, loaded only with a valid item
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_d1_reg <= raw_press;
            s1_dt_reg <= s1_dt_next;
        end
        if (en2 && s1_v_reg)
        begin
            s2_d1_reg    <= s1_d1_reg;
            s2_ptemp_reg <= s2_ptemp_next;
            s2_poff_reg  <= s2_poff_next;
            s2_psens_reg <= s2_psens_next;
            s2_psq_reg   <= s2_psq_next;
        end
        if (en3 && s2_v_reg)
            s3_data_reg <= s3_data_next;
    end

    assign out_valid = s3_v_reg;
    assign out_data  = s3_data_reg;

endmodule

`default_nettype wire

### hw/rtl/bpc_corr.sv
// Second-order correction stages: low and very-low temperature terms.
// Three register stages: squares, constant multiples, correction sums.
// Depends on bpc_pkg.
`default_nettype none

module bpc_corr (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bpc_pkg::first_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bpc_pkg::corr_t       out_data
);

    localparam int DW  = bpc_pkg::TEMP_W + 1;
    localparam int SQW = 2 * DW;

    logic en4, en5, en6;

    // Stage 4: squares of the temperature offsets
    logic                         s4_v_reg;
    bpc_pkg::first_t              s4_base_reg;
    logic                         s4_low_reg, s4_low_next;
    logic                         s4_vlow_reg, s4_vlow_next;
    logic [34:0]                  s4_dsq_reg, s4_dsq_next;
    logic [34:0]                  s4_esq_reg, s4_esq_next;
    logic signed [DW-1:0]         d_val, e_val;
    logic signed [SQW-1:0]        dsq_full, esq_full;

    // Stage 5: constant multiples and corrected temperature
    logic                                s5_v_reg;
    logic [bpc_pkg::RAW_W-1:0]           s5_d1_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]   s5_temp_reg, s5_temp_next;
    logic signed [bpc_pkg::OFF_W-1:0]    s5_off_reg;
    logic signed [bpc_pkg::SENS_W-1:0]   s5_sens_reg;
    logic                                s5_low_reg, s5_vlow_reg;
    logic [36:0]                         s5_sq5_reg, s5_sq5_next;
    logic [36:0]                         s5_esq7_reg, s5_esq7_next;
    logic [37:0]                         s5_esq11_reg, s5_esq11_next;
    logic [37:0]                         esq7_full;

    // Stage 6: correction sums
    logic                         s6_v_reg;
    bpc_pkg::corr_t               s6_data_reg, s6_data_next;

    assign en6      = !s6_v_reg || out_ready;
    assign en5      = !s5_v_reg || en6;
    assign en4      = !s4_v_reg || en5;
    assign in_ready = en4;

    // Offsets from 20.00 C and -15.00 C, and their squares
    always_comb
    begin
        s4_low_next  = in_data.temp < bpc_pkg::TEMP_REF;
        s4_vlow_next = in_data.temp < bpc_pkg::TEMP_VLOW;
        d_val        = DW'(in_data.temp) - DW'(bpc_pkg::TEMP_REF);
        e_val        = DW'(in_data.temp) - DW'(bpc_pkg::TEMP_VLOW);
        dsq_full     = SQW'(d_val) * SQW'(d_val);
        esq_full     = SQW'(e_val) * SQW'(e_val);
        s4_dsq_next  = dsq_full[34:0];
        s4_esq_next  = esq_full[34:0];
    end

    // Multiply by 5, 7 and 11 with shifts, adds and a subtract; subtract T2 when cold
    always_comb
    begin
        s5_sq5_next   = {2'b0, s4_dsq_reg} + {s4_dsq_reg, 2'b0};
        esq7_full     = {s4_esq_reg, 3'b0} - {3'b0, s4_esq_reg};
        s5_esq7_next  = esq7_full[36:0];
        s5_esq11_next = {s4_esq_reg, 3'b0} + {2'b0, s4_esq_reg, 1'b0} + {3'b0, s4_esq_reg};
        s5_temp_next  = s4_low_reg ? s4_base_reg.temp - $signed({2'b0, s4_base_reg.t2})
                                   : s4_base_reg.temp;
    end

    // OFF2 and SENS2, zero at or above 20.00 C
    always_comb
    begin
        s6_data_next.d1    = s5_d1_reg;
        s6_data_next.temp  = s5_temp_reg;
        s6_data_next.off   = s5_off_reg;
        s6_data_next.sens  = s5_sens_reg;
        s6_data_next.off2  = '0;
        s6_data_next.sens2 = '0;
        if (s5_low_reg)
        begin
            s6_data_next.off2  = {2'b0, s5_sq5_reg[36:1]}
                               + (s5_vlow_reg ? {1'b0, s5_esq7_reg} : 38'd0);
            s6_data_next.sens2 = {3'b0, s5_sq5_reg[36:2]}
                               + (s5_vlow_reg ? {1'b0, s5_esq11_reg[37:1]} : 38'd0);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                s4_v_reg <= in_valid;
            if (en5)
                s5_v_reg <= s4_v_reg;
            if (en6)
                s6_v_reg <= s5_v_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en4 && in_valid)
        begin
            s4_base_reg <= in_data;
            s4_low_reg  <= s4_low_next;
            s4_vlow_reg <= s4_vlow_next;
            s4_dsq_reg  <= s4_dsq_next;
            s4_esq_reg  <= s4_esq_next;
        end
        if (en5 && s4_v_reg)
        begin
            s5_d1_reg    <= s4_base_reg.d1;
            s5_temp_reg  <= s5_temp_next;
            s5_off_reg   <= s4_base_reg.off;
            s5_sens_reg  <= s4_base_reg.sens;
            s5_low_reg   <= s4_low_reg;
            s5_vlow_reg  <= s4_vlow_reg;
            s5_sq5_reg   <= s5_sq5_next;
            s5_esq7_reg  <= s5_esq7_next;
            s5_esq11_reg <= s5_esq11_next;
        end
        if (en6 && s5_v_reg)
            s6_data_reg <= s6_data_next;
    end

    assign out_valid = s6_v_reg;
    assign out_data  = s6_data_reg;

endmodule

`default_nettype wire

### hw/rtl/bpc_press.sv
// Pressure stages: corrected OFF and SENS, raw pressure product, final scaling.
// Three register stages; the last one is the output register of the block.
// Depends on bpc_pkg.
`default_nettype none

module bpc_press (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire bpc_pkg::corr_t           in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [bpc_pkg::PRESS_W-1:0] pressure_out,
    output logic signed [bpc_pkg::TEMP_W-1:0]  temp_out
);

    localparam int CW  = 40;
    localparam int SQ_W = 19;
    localparam int PW  = 44;
    localparam int DFW = 46;

    logic en7, en8, en9;

    // Stage 7: OFF - OFF2 and (SENS - SENS2) / 2^21
    logic                                s7_v_reg;
    logic [bpc_pkg::RAW_W-1:0]           s7_d1_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]   s7_temp_reg;
    logic signed [CW-1:0]                s7_offc_reg, s7_offc_next;
    logic signed [SQ_W-1:0]              s7_sensq_reg, s7_sensq_next;
    logic signed [CW-1:0]                sensc, sensq_full;

    // Stage 8: D1 times scaled sensitivity
    logic                                s8_v_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]   s8_temp_reg;
    logic signed [CW-1:0]                s8_offc_reg;
    logic signed [PW-1:0]                s8_prod_reg, s8_prod_next;

    // Stage 9: output register
    logic                                s9_v_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]   s9_temp_reg;
    logic signed [bpc_pkg::PRESS_W-1:0]  s9_press_reg, s9_press_next;
    logic signed [DFW-1:0]               diff, press_full;

    assign en9      = !s9_v_reg || out_ready;
    assign en8      = !s8_v_reg || en9;
    assign en7      = !s7_v_reg || en8;
    assign in_ready = en7;

    // Apply corrections; scale sensitivity with truncation toward zero
    always_comb
    begin
        s7_offc_next  = CW'(in_data.off) - $signed({2'b0, in_data.off2});
        sensc         = CW'(in_data.sens) - $signed({2'b0, in_data.sens2});
        sensq_full    = (sensc + (sensc[CW-1] ? 40'sd2097151 : 40'sd0)) >>> 21;
        s7_sensq_next = $signed(sensq_full[SQ_W-1:0]);
    end

    assign s8_prod_next = PW'($signed({1'b0, s7_d1_reg})) * PW'(s7_sensq_reg);

    // Subtract offset, divide by 2^15 toward zero, wrap to 32 bits
    always_comb
    begin
        diff          = DFW'(s8_prod_reg) - DFW'(s8_offc_reg);
        press_full    = (diff + (diff[DFW-1] ? 46'sd32767 : 46'sd0)) >>> 15;
        s9_press_next = $signed(press_full[bpc_pkg::PRESS_W-1:0]);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            s9_v_reg <= 1'b0;
        end
        else
        begin
            if (en7)
                s7_v_reg <= in_valid;
            if (en8)
                s8_v_reg <= s7_v_reg;
            if (en9)
                s9_v_reg <= s8_v_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en7 && in_valid)
        begin
            s7_d1_reg    <= in_data.d1;
            s7_temp_reg  <= in_data.temp;
            s7_offc_reg  <= s7_offc_next;
            s7_sensq_reg <= s7_sensq_next;
        end
        if (en8 && s7_v_reg)
        begin
            s8_temp_reg <= s7_temp_reg;
            s8_offc_reg <= s7_offc_reg;
            s8_prod_reg <= s8_prod_next;
        end
        if (en9 && s8_v_reg)
        begin
            s9_temp_reg  <= s8_temp_reg;
            s9_press_reg <= s9_press_next;
        end
    end

    assign out_valid    = s9_v_reg;
    assign pressure_out = s9_press_reg;
    assign temp_out     = s9_temp_reg;

endmodule

`default_nettype wire

### hw/rtl/bpc_checker.sv
// Port-level checker for the pressure compensation block, with its bind statement.
// Tracks items in flight against the pipeline depth.
// Depends on bpc_pkg and the top level barometric_pressure_compensation.
`default_nettype none

module bpc_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [bpc_pkg::PRESS_W-1:0] pressure_out,
    input  wire logic signed [bpc_pkg::TEMP_W-1:0]  temp_out
);

    localparam int CNT_W = $clog2(bpc_pkg::PIPE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count items in flight
    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + 1'b1;
        else if (!in_acc && out_acc)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressure_out) && $stable(temp_out))
        else $error("stalled result item changed or vanished");

    // No result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result item with nothing in flight");

    // Backpressure only when every stage is full
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> count_reg == CNT_W'(bpc_pkg::PIPE_DEPTH))
        else $error("input stalled while the pipeline has room");

    // Never more items in flight than stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(bpc_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .pressure_out (out_ch.pressure_out),
    .temp_out     (out_ch.temp_out)
);

`default_nettype wire
